// ===== hw/rtl/cartridge_bank_mapper_core_defines.svh =====
// assertion macros shared by the cartridge bank mapper rtl
`ifndef CARTRIDGE_BANK_MAPPER_CORE_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CBM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cbm_pkg.sv =====
// types and constants of the cartridge bank mapper
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

  // result kind codes
  typedef enum logic [2:0] {
    KIND_ROM_READ  = 3'd0,
    KIND_RAM_READ  = 3'd1,
    KIND_RAM_WRITE = 3'd2,
    KIND_CONTROL   = 3'd3,
    KIND_RAM_OFF   = 3'd4,
    KIND_INVALID   = 3'd5
  } kind_e;

  // control register region, address bits 14:13 of a write below 0x8000
  typedef enum logic [1:0] {
    REGION_RAM_EN    = 2'b00,
    REGION_LOW_BANK  = 2'b01,
    REGION_HIGH_BANK = 2'b10,
    REGION_MODE      = 2'b11
  } region_e;

  localparam int unsigned AddrW     = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned MapW      = 21;
  localparam int unsigned MaskW     = 7;
  localparam int unsigned LowBankW  = 5;
  localparam int unsigned HighBankW = 2;

  localparam logic [MaskW-1:0]    RomBankMaskReset = 7'h7F;
  localparam logic [LowBankW-1:0] LowBankReset     = 5'd1;
  localparam logic [3:0]          RamEnableKey     = 4'hA;
  // 0xA000-0xBFFF: top three address bits
  localparam logic [2:0]          RamWindowTop     = 3'b101;

endpackage

`default_nettype wire

// ===== hw/rtl/cartridge_bank_mapper_core.sv =====
// cartridge bank mapper: bus access in, access kind and translated address out
//
// Usage:
//   input channel (in_valid_i / in_stall_o) carries one bus access per transfer:
//   is_write_i, address_i, write_data_i. Writes below 0x8000 program the bank,
//   mode and ram-enable registers; reads there give the physical rom address,
//   accesses to 0xA000-0xBFFF give the physical ram address or ram-disabled.
//   output channel (out_valid_o / out_stall_i) carries access_kind_o and
//   mapped_address_o, one result per accepted access, in order.
//   config channel (cfg_valid_i / cfg_ready_o) writes rom_bank_mask; it is
//   always ready. Write it only while the block is idle; it is not enforced.
// Timing:
//   an access passes an input register, then the decode and translate logic
//   feeding the result register. One access per cycle is sustained while the
//   output is not stalled, as both registers then advance every cycle.
// Reset:
//   mask 0x7F, low bank 1, high bank 0, rom mode, ram disabled; both stages empty.
// Stall:
//   a stalled result holds; the input register still fills behind it, and the
//   input channel stalls only when both stages are full and the output stalls.
`timescale 1ns / 1ps
`default_nettype none

`include "cartridge_bank_mapper_core_defines.svh"

module cartridge_bank_mapper_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // config channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [cbm_pkg::MaskW-1:0]          cfg_data_i,
  // input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               is_write_i,
  input  wire logic [cbm_pkg::AddrW-1:0]          address_i,
  input  wire logic [cbm_pkg::DataW-1:0]          write_data_i,
  // output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [2:0]                              access_kind_o,
  output logic [cbm_pkg::MapW-1:0]                mapped_address_o
);

  // mapper state
  logic [cbm_pkg::MaskW-1:0]     rom_bank_mask_q;
  logic [cbm_pkg::LowBankW-1:0]  low_bank_q, low_bank_d;
  logic [cbm_pkg::HighBankW-1:0] high_bank_q, high_bank_d;
  logic                          ram_mode_q, ram_mode_d;
  logic                          ram_enabled_q, ram_enabled_d;

  // input register
  logic                          s1_valid_q;
  logic                          s1_write_q;
  logic [cbm_pkg::AddrW-1:0]     s1_addr_q;
  logic [cbm_pkg::DataW-1:0]     s1_data_q;

  // result register
  logic                          out_valid_q;
  cbm_pkg::kind_e                out_kind_q, out_kind_d;
  logic [cbm_pkg::MapW-1:0]      out_addr_q, out_addr_d;

  logic                          out_ready;
  logic                          s1_adv;
  logic                          in_xfer;
  logic [cbm_pkg::MaskW-1:0]     bank;
  logic [cbm_pkg::HighBankW-1:0] ram_page;
  logic [4:0]                    low_sel;

  // handshake
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bank_mask_q <= cbm_pkg::RomBankMaskReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rom_bank_mask_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_write_q <= is_write_i;
      s1_addr_q  <= address_i;
      s1_data_q  <= write_data_i;
    end
  end

  // current bank numbers
  assign bank     = {high_bank_q, low_bank_q} & rom_bank_mask_q;
  assign ram_page = ram_mode_q ? high_bank_q : '0;
  assign low_sel  = s1_data_q[4:0];

  // decode, translate and control register update
  always_comb begin
    out_kind_d    = cbm_pkg::KIND_INVALID;
    out_addr_d    = '0;
    low_bank_d    = low_bank_q;
    high_bank_d   = high_bank_q;
    ram_mode_d    = ram_mode_q;
    ram_enabled_d = ram_enabled_q;
    if (!s1_addr_q[15]) begin
      if (s1_write_q) begin
        out_kind_d = cbm_pkg::KIND_CONTROL;
        unique case (cbm_pkg::region_e'(s1_addr_q[14:13]))
          cbm_pkg::REGION_RAM_EN: begin
            ram_enabled_d = (s1_data_q[3:0] == cbm_pkg::RamEnableKey);
          end
          cbm_pkg::REGION_LOW_BANK: begin
            low_bank_d = (low_sel == '0) ? cbm_pkg::LowBankReset : low_sel;
          end
          cbm_pkg::REGION_HIGH_BANK: begin
            high_bank_d = s1_data_q[1:0];
          end
          cbm_pkg::REGION_MODE: begin
            ram_mode_d  = s1_data_q[0];
            high_bank_d = '0;
          end
          default: begin
            ram_mode_d = ram_mode_q;
          end
        endcase
      end else begin
        out_kind_d = cbm_pkg::KIND_ROM_READ;
        if (!s1_addr_q[14]) begin
          // first window: offset by bank bits 6:5 in ram mode only
          out_addr_d = {(ram_mode_q ? bank[6:5] : 2'b00), 5'b0, s1_addr_q[13:0]};
        end else begin
          out_addr_d = {bank, s1_addr_q[13:0]};
        end
      end
    end else if (s1_addr_q[15:13] == cbm_pkg::RamWindowTop) begin
      if (!ram_enabled_q) begin
        out_kind_d = cbm_pkg::KIND_RAM_OFF;
      end else begin
        out_kind_d = s1_write_q ? cbm_pkg::KIND_RAM_WRITE : cbm_pkg::KIND_RAM_READ;
        out_addr_d = {6'b0, ram_page, s1_addr_q[12:0]};
      end
    end
  end

  // mapper state, updated as each access leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_bank_q    <= cbm_pkg::LowBankReset;
      high_bank_q   <= '0;
      ram_mode_q    <= 1'b0;
      ram_enabled_q <= 1'b0;
    end else if (s1_adv) begin
      low_bank_q    <= low_bank_d;
      high_bank_q   <= high_bank_d;
      ram_mode_q    <= ram_mode_d;
      ram_enabled_q <= ram_enabled_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_kind_q <= out_kind_d;
      out_addr_q <= out_addr_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign access_kind_o    = out_kind_q;
  assign mapped_address_o = out_addr_q;

  // checks
  `CBM_ASSERT_IMPL(a_low_bank_nonzero, 1'b1, low_bank_q != '0, "low bank is zero")
  `CBM_ASSERT_IMPL(a_unused_addr_zero,
    out_valid_q && (out_kind_q == cbm_pkg::KIND_CONTROL ||
    out_kind_q == cbm_pkg::KIND_RAM_OFF || out_kind_q == cbm_pkg::KIND_INVALID),
    out_addr_q == '0, "address set on a kind without address")
  `CBM_ASSERT_IMPL(a_stall_full, in_stall_o, s1_valid_q && out_valid_q && out_stall_i,
    "input stalled with a free stage")
  `CBM_ASSERT_NEXT(a_advance_fills_out, s1_adv, out_valid_q, "advanced item lost")
  `CBM_ASSERT_NEXT(a_mode_clears_high,
    s1_adv && s1_write_q && !s1_addr_q[15] && s1_addr_q[14:13] == cbm_pkg::REGION_MODE,
    high_bank_q == '0, "mode write left high bank set")

endmodule

`default_nettype wire

// ===== tb/sv/mapper_checker.sv =====
// bank mapper checker: tracks banking state, predicts each translation and compares results
`timescale 1ns / 1ps
module mapper_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [cbm_pkg::MaskW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          is_write_i,
  input  logic [cbm_pkg::AddrW-1:0]     address_i,
  input  logic [cbm_pkg::DataW-1:0]     write_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [2:0]                    access_kind_i,
  input  logic [cbm_pkg::MapW-1:0]      mapped_address_i,
  output int                            mismatches_o,
  output int                            pending_o
);

  typedef struct packed {
    cbm_pkg::kind_e               kind;
    logic [cbm_pkg::MapW-1:0]     addr;
  } translation_t;

  // shadow copy of the mapper registers
  logic [cbm_pkg::MaskW-1:0]     bank_mask;
  logic [cbm_pkg::LowBankW-1:0]  low_bank;
  logic [cbm_pkg::HighBankW-1:0] high_bank;
  logic                          ram_mode;
  logic                          ram_on;

  translation_t pending_translations[$];

  // work out the result of one access and apply its register update
  function automatic translation_t translate_access(input logic wr,
                                                   input logic [cbm_pkg::AddrW-1:0] addr,
                                                   input logic [cbm_pkg::DataW-1:0] data);
    translation_t res;
    logic [cbm_pkg::MaskW-1:0] bank;
    res.kind = cbm_pkg::KIND_INVALID;
    res.addr = '0;
    bank = {high_bank, low_bank} & bank_mask;
    if (!addr[15]) begin
      if (wr) begin
        res.kind = cbm_pkg::KIND_CONTROL;
        case (cbm_pkg::region_e'(addr[14:13]))
          cbm_pkg::REGION_RAM_EN: begin
            ram_on = (data[3:0] == cbm_pkg::RamEnableKey);
          end
          cbm_pkg::REGION_LOW_BANK: begin
            // bank zero is not selectable, it maps to bank one
            low_bank = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
          end
          cbm_pkg::REGION_HIGH_BANK: begin
            high_bank = data[1:0];
          end
          cbm_pkg::REGION_MODE: begin
            ram_mode  = data[0];
            high_bank = '0;
          end
        endcase
      end else begin
        res.kind = cbm_pkg::KIND_ROM_READ;
        if (addr[14]) begin
          res.addr = {bank, addr[13:0]};
        end else if (ram_mode) begin
          // first window offset by bank bits 6:5 in ram mode
          res.addr = {bank[6:5], 5'd0, addr[13:0]};
        end else begin
          res.addr = {7'd0, addr[13:0]};
        end
      end
    end else if (addr[15:13] == cbm_pkg::RamWindowTop) begin
      if (!ram_on) begin
        res.kind = cbm_pkg::KIND_RAM_OFF;
      end else begin
        res.kind = wr ? cbm_pkg::KIND_RAM_WRITE : cbm_pkg::KIND_RAM_READ;
        res.addr = {6'd0, (ram_mode ? high_bank : 2'b00), addr[12:0]};
      end
    end
    return res;
  endfunction

  // watch the three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    translation_t want;
    if (!rst_ni) begin
      bank_mask    = cbm_pkg::RomBankMaskReset;
      low_bank     = 5'd1;
      high_bank    = '0;
      ram_mode     = 1'b0;
      ram_on       = 1'b0;
      mismatches_o = 0;
      pending_o    = 0;
      pending_translations.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        bank_mask = cfg_data_i;
      end
      // result transfer: compare with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (pending_translations.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d address 0x%06h",
                   $time, access_kind_i, mapped_address_i);
          mismatches_o++;
        end else begin
          want = pending_translations.pop_front();
          pending_o--;
          if (access_kind_i !== want.kind) begin
            $display("%0t: access_kind mismatch, expected %0d, got %0d",
                     $time, want.kind, access_kind_i);
            mismatches_o++;
          end
          if (mapped_address_i !== want.addr) begin
            $display("%0t: mapped_address mismatch, expected 0x%06h, got 0x%06h",
                     $time, want.addr, mapped_address_i);
            mismatches_o++;
          end
        end
      end
      // access transfer: predict its result
      if (in_valid_i && !in_stall_i) begin
        pending_translations.insert(pending_translations.size(),
                                    translate_access(is_write_i, address_i, write_data_i));
        pending_o++;
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the bank mapper testbench: clock, reset, access stimulus, result stalls and verdict
`timescale 1ns / 1ps
module testbench;

  localparam int HoldCycles   = 300;
  localparam int PhaseItems   = 200;
  localparam int Phases       = 8;
  localparam int DrainLimit   = 5000;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [cbm_pkg::MaskW-1:0]     cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic                          is_write;
  logic [cbm_pkg::AddrW-1:0]     address;
  logic [cbm_pkg::DataW-1:0]     write_data;
  logic                          out_valid;
  logic                          out_stall;
  logic [2:0]                    access_kind;
  logic [cbm_pkg::MapW-1:0]      mapped_address;
  int                            mismatches;
  int                            pending;

  // idling controls set by the stimulus for the sender and the receiver
  logic               sender_quiet;
  logic               recv_quiet;
  logic               hold_req;

  cartridge_bank_mapper_core DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .is_write_i       (is_write),
    .address_i        (address),
    .write_data_i     (write_data),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .access_kind_o    (access_kind),
    .mapped_address_o (mapped_address)
  );

  mapper_checker watch (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .is_write_i       (is_write),
    .address_i        (address),
    .write_data_i     (write_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .access_kind_i    (access_kind),
    .mapped_address_i (mapped_address),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // gap length: mostly none, often short, now and then long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one access and hold it until the transfer happens
  task automatic offer_access(input logic wr, input logic [cbm_pkg::AddrW-1:0] addr,
                              input logic [cbm_pkg::DataW-1:0] data);
    int gap;
    gap = sender_quiet ? 0 : idle_length();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    is_write   <= wr;
    address    <= addr;
    write_data <= data;
    do @(posedge clk); while (in_stall);
  endtask

  // write the bank mask once the mapper has drained
  task automatic program_mask(input logic [cbm_pkg::MaskW-1:0] mask);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_data  <= mask;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        n = recv_quiet ? 0 : idle_length();
        out_stall <= (n != 0);
        repeat ((n == 0) ? 1 : n) @(negedge clk);
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // access stimulus and verdict
  initial begin
    logic [cbm_pkg::MaskW-1:0] mask_plan [Phases];
    logic                      wr;
    logic [cbm_pkg::AddrW-1:0] addr;
    logic [cbm_pkg::DataW-1:0] data;
    int                        sel;
    int                        drain;

    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    is_write     = 1'b0;
    address      = '0;
    write_data   = '0;
    sender_quiet = 1'b0;
    recv_quiet   = 1'b0;
    hold_req     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: window edges, every register region, ram on and off, unmapped space
    offer_access(1'b0, 16'h0000, 8'h00);
    offer_access(1'b0, 16'h3FFF, 8'hFF);
    offer_access(1'b0, 16'h4000, 8'h00);
    offer_access(1'b0, 16'h7FFF, 8'h00);
    offer_access(1'b0, 16'hA000, 8'h00);
    offer_access(1'b1, 16'hA123, 8'h55);
    offer_access(1'b1, 16'h0000, 8'h0A);
    offer_access(1'b0, 16'hBFFF, 8'h00);
    offer_access(1'b1, 16'hA000, 8'hFF);
    offer_access(1'b1, 16'h2000, 8'h00);
    offer_access(1'b0, 16'h4000, 8'h00);
    offer_access(1'b1, 16'h2000, 8'hE0);
    offer_access(1'b1, 16'h3FFF, 8'hFF);
    offer_access(1'b1, 16'h4000, 8'hFF);
    offer_access(1'b0, 16'h7FFF, 8'h00);
    offer_access(1'b0, 16'h0123, 8'h00);
    offer_access(1'b1, 16'h6000, 8'h01);
    offer_access(1'b1, 16'h5FFF, 8'h02);
    offer_access(1'b0, 16'h1234, 8'h00);
    offer_access(1'b0, 16'hB000, 8'h00);
    offer_access(1'b1, 16'h8000, 8'hFF);
    offer_access(1'b0, 16'h9FFF, 8'h00);
    offer_access(1'b0, 16'hC000, 8'h00);
    offer_access(1'b1, 16'hFFFF, 8'hAA);
    offer_access(1'b1, 16'h1FFF, 8'hAB);
    offer_access(1'b1, 16'h7FFF, 8'hFE);
    offer_access(1'b0, 16'hA000, 8'h00);

    // random phases, each under its own bank mask
    mask_plan[0] = 7'h00;
    mask_plan[1] = 7'h7F;
    mask_plan[2] = 7'h1F;
    mask_plan[3] = 7'h55;
    mask_plan[4] = 7'h03;
    mask_plan[5] = 7'h2A;
    mask_plan[6] = 7'($urandom_range(0, 127));
    mask_plan[7] = 7'h7F;
    for (int p = 0; p < Phases; p++) begin
      program_mask(mask_plan[p]);
      // phase 1 keeps offering while results are held back; phase 3 never idles
      sender_quiet = (p == 1) || (p == 3);
      recv_quiet   = (p == 3);
      if (p == 1) hold_req = 1'b1;
      for (int i = 0; i < PhaseItems; i++) begin
        sel  = int'($urandom_range(0, 99));
        wr   = 1'($urandom_range(0, 1));
        addr = 16'($urandom_range(0, 16'hFFFF));
        data = 8'($urandom_range(0, 255));
        if (sel < 35) begin
          // register write, often with the ram enable key
          wr       = 1'b1;
          addr[15] = 1'b0;
          if ($urandom_range(0, 1) != 0) data[3:0] = cbm_pkg::RamEnableKey;
        end else if (sel < 65) begin
          wr       = 1'b0;
          addr[15] = 1'b0;
        end else if (sel < 85) begin
          addr[15:13] = cbm_pkg::RamWindowTop;
        end else if (sel < 95) begin
          // unmapped space only
          addr[15] = 1'b1;
          if (addr[15:13] == cbm_pkg::RamWindowTop) addr[14] = 1'b1;
        end
        offer_access(wr, addr, data);
      end
    end

    // drain and verdict
    sender_quiet = 1'b0;
    recv_quiet   = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;
    drain = 0;
    while (pending != 0 && drain < DrainLimit) begin
      @(negedge clk);
      drain++;
    end
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
